// ===== hdl/ode_pkg.sv =====
// Shared types, opcodes and defaults for the ordered deque engine.
`timescale 1ns / 1ps

package ode_pkg;

	localparam int DEF_CAPACITY   = 16;
	localparam int DEF_DATA_WIDTH = 32;

	localparam int KIND_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// operation codes
	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_INSERT     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd4;
	localparam logic [KIND_W-1:0] KIND_REMOVE     = 3'd5;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd3;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic signed [VALUE_W-1:0] value;
	} in_word_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] popped;
		logic [STATUS_W-1:0]       status;
		logic [COUNT_W-1:0]        count;
	} out_word_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic              capture;  // latch per-cell compare flag
		logic              apply;    // perform the shift/write
		logic [KIND_W-1:0] op;
	} cell_ctrl_t;

endpackage

// ===== hdl/ode_cell.sv =====
// One storage cell of the deque: holds an entry, compares it, shifts with neighbors.
`timescale 1ns / 1ps

module ode_cell #(
	parameter int DATA_WIDTH = ode_pkg::DEF_DATA_WIDTH,
	parameter int CNT_W      = 5,
	parameter int IDX        = 0
) (
	input  logic                  clk,
	input  ode_pkg::cell_ctrl_t   ctrl,
	input  logic [CNT_W-1:0]      count,
	input  logic [DATA_WIDTH-1:0] din,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic [DATA_WIDTH-1:0] right_data,
	input  logic                  hit_in,
	input  logic [DATA_WIDTH-1:0] tail_in,
	output logic [DATA_WIDTH-1:0] entry,
	output logic                  hit_out,
	output logic [DATA_WIDTH-1:0] tail_out
);

	logic [DATA_WIDTH-1:0] entry_q;
	logic                  flag_q;
	logic                  valid;
	logic                  is_tail;
	logic                  is_last;
	logic                  cmp_hit;

	assign valid   = CNT_W'(IDX) < count;
	assign is_tail = count == CNT_W'(IDX);
	assign is_last = count == CNT_W'(IDX + 1);

	// remove looks for equality, insert for the first entry not below the value
	assign cmp_hit = (ctrl.op == ode_pkg::KIND_REMOVE) ? (entry_q == din)
		: !($signed(din) > $signed(entry_q));

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			flag_q <= valid && cmp_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.apply) begin
			case (ctrl.op)
				ode_pkg::KIND_PUSH_FRONT: begin
					entry_q <= left_data;
				end
				ode_pkg::KIND_PUSH_BACK: begin
					if (is_tail) begin
						entry_q <= din;
					end
				end
				ode_pkg::KIND_INSERT: begin
					if (hit_in) begin
						entry_q <= left_data;
					end else if (flag_q || is_tail) begin
						entry_q <= din;
					end
				end
				ode_pkg::KIND_POP_FRONT: begin
					entry_q <= right_data;
				end
				ode_pkg::KIND_REMOVE: begin
					if (hit_in || flag_q) begin
						entry_q <= right_data;
					end
				end
				default: begin
					entry_q <= entry_q;
				end
			endcase
		end
	end

	assign entry    = entry_q;
	assign hit_out  = hit_in | flag_q;
	assign tail_out = is_last ? entry_q : tail_in;

endmodule

// ===== hdl/ordered_deque_engine_unit.sv =====
// Top level of the ordered deque engine: controller, cell row and result register.
`timescale 1ns / 1ps

// Channel   Ports                    Handshake
// -------   ----------------------   ---------------------------------------------
// command   start, busy, cmd         word taken at a clock edge with start & !busy
// result    done, result             word shown for one cycle while done is high
//
// In the accept cycle of each command, every cell latches its compare
// flag against the operand; in the following cycle (busy high) the flags ripple along
// the row, each cell shifts or writes, and the result word is registered. done and
// result follow in the next cycle, while a new command may already be taken.
// arst_n clears the controller, the entry count and done; cell contents need no reset.
// The receiver cannot stall: every result is presented exactly once.

module ordered_deque_engine_unit #(
	parameter int CAPACITY   = ode_pkg::DEF_CAPACITY,
	parameter int DATA_WIDTH = ode_pkg::DEF_DATA_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ode_pkg::in_word_t cmd,
	output logic              done,
	output ode_pkg::out_word_t result
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int KW = ode_pkg::KIND_W;

	ode_pkg::state_t     state_q;
	ode_pkg::state_t     state_nxt;
	ode_pkg::cell_ctrl_t ctrl;

	logic                  accept;
	logic [KW-1:0]         kind_s1;
	logic [DATA_WIDTH-1:0] data_s1;
	logic [DATA_WIDTH-1:0] vin;
	logic [63:0]           vin_wide;
	logic [DATA_WIDTH-1:0] din;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_nxt;

	logic [DATA_WIDTH-1:0] entry [CAPACITY];
	logic                  hit   [CAPACITY+1];
	logic [DATA_WIDTH-1:0] tail  [CAPACITY+1];

	logic                     full;
	logic                     empty;
	logic                     found;
	logic                     is_push;
	logic                     is_pop;
	logic [ode_pkg::STATUS_W-1:0] status;
	logic [DATA_WIDTH-1:0]    pop_data;
	logic [63:0]              pop_wide;

	logic                done_q;
	ode_pkg::out_word_t  result_q;

	assign accept   = start && !busy;
	assign vin_wide = 64'(cmd.value);
	assign vin      = vin_wide[DATA_WIDTH-1:0];

	// ---------------- controller ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ode_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ode_pkg::ST_IDLE: begin
				if (start) begin
					state_nxt = ode_pkg::ST_EXEC;
				end
			end
			ode_pkg::ST_EXEC: begin
				state_nxt = ode_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = ode_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy         = 1'b0;
		ctrl.capture = 1'b0;
		ctrl.apply   = 1'b0;
		ctrl.op      = cmd.kind;
		din          = vin;
		unique case (state_q)
			ode_pkg::ST_IDLE: begin
				ctrl.capture = start;
			end
			ode_pkg::ST_EXEC: begin
				busy       = 1'b1;
				ctrl.op    = kind_s1;
				din        = data_s1;
				ctrl.apply = (status == ode_pkg::STAT_OK);
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	// operand held for the execute cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= cmd.kind;
			data_s1 <= vin;
		end
	end

	// ---------------- cell row ----------------
	assign hit[0]  = 1'b0;
	assign tail[0] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_d;
		logic [DATA_WIDTH-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = din;   // push front enters here
		end else begin : g_mid_l
			assign left_d = entry[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_d = entry[i];
		end else begin : g_mid_r
			assign right_d = entry[i+1];
		end

		ode_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.CNT_W      (CNT_W),
			.IDX        (i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.count      (count_q),
			.din        (din),
			.left_data  (left_d),
			.right_data (right_d),
			.hit_in     (hit[i]),
			.tail_in    (tail[i]),
			.entry      (entry[i]),
			.hit_out    (hit[i+1]),
			.tail_out   (tail[i+1])
		);
	end

	// ---------------- status and count ----------------
	assign full    = count_q == CNT_W'(CAPACITY);
	assign empty   = count_q == '0;
	assign found   = hit[CAPACITY];
	assign is_push = (kind_s1 == ode_pkg::KIND_PUSH_FRONT) || (kind_s1 == ode_pkg::KIND_PUSH_BACK)
		|| (kind_s1 == ode_pkg::KIND_INSERT);
	assign is_pop  = (kind_s1 == ode_pkg::KIND_POP_FRONT) || (kind_s1 == ode_pkg::KIND_POP_BACK);

	always_comb begin
		status = ode_pkg::STAT_OK;
		if (is_push && full) begin
			status = ode_pkg::STAT_FULL;
		end else if (is_pop && empty) begin
			status = ode_pkg::STAT_EMPTY;
		end else if ((kind_s1 == ode_pkg::KIND_REMOVE) && !found) begin
			status = ode_pkg::STAT_NOTFOUND;
		end
	end

	always_comb begin
		count_nxt = count_q;
		pop_data  = '0;
		if (status == ode_pkg::STAT_OK) begin
			if (is_push) begin
				count_nxt = count_q + 1'b1;
			end else if (is_pop || (kind_s1 == ode_pkg::KIND_REMOVE)) begin
				count_nxt = count_q - 1'b1;
			end
			if (kind_s1 == ode_pkg::KIND_POP_FRONT) begin
				pop_data = entry[0];
			end else if (kind_s1 == ode_pkg::KIND_POP_BACK) begin
				pop_data = tail[CAPACITY];   // last valid entry, rippled along the row
			end
		end
	end

	assign pop_wide = 64'(pop_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= busy;
			if (busy) begin
				count_q <= count_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy) begin
			result_q.popped <= pop_wide[ode_pkg::VALUE_W-1:0];
			result_q.status <= status;
			result_q.count  <= ode_pkg::COUNT_W'(count_nxt);
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== dv/ordered_deque_engine_unit_tb.sv =====
// Self-checking testbench for the ordered deque engine: directed corners, then random traffic.
`timescale 1ns / 1ps

module ordered_deque_engine_unit_tb;

	localparam int CAPACITY       = ode_pkg::DEF_CAPACITY;
	localparam int RANDOM_WORDS   = 1900;
	localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles
	localparam int DRAIN_CYCLES   = 8;

	typedef enum int {
		MIX_FILL,
		MIX_DRAIN,
		MIX_EVEN
	} mix_t;

	// Shadow deque plus the list of results still owed by the block.
	class deque_ledger;
		logic signed [ode_pkg::VALUE_W-1:0] held[$];
		ode_pkg::out_word_t                 expected_words[$];
		int mismatches;
		int n_words;
		int n_checked;
		int n_full;
		int n_empty;
		int n_missing;
		int n_removed;
		int peak;

		function new();
			mismatches = 0;
			n_words    = 0;
			n_checked  = 0;
			n_full     = 0;
			n_empty    = 0;
			n_missing  = 0;
			n_removed  = 0;
			peak       = 0;
		endfunction

		// Work out the result of one accepted command word.
		function void note_command(ode_pkg::in_word_t w);
			ode_pkg::out_word_t                 exp_word;
			logic signed [ode_pkg::VALUE_W-1:0] v;
			int                                 pos;
			exp_word        = '0;
			exp_word.status = ode_pkg::STAT_OK;
			v               = w.value;
			n_words++;
			case (w.kind)
				ode_pkg::KIND_PUSH_FRONT, ode_pkg::KIND_PUSH_BACK, ode_pkg::KIND_INSERT: begin
					if (held.size() >= CAPACITY) begin
						exp_word.status = ode_pkg::STAT_FULL;
						n_full++;
					end else if (w.kind == ode_pkg::KIND_PUSH_FRONT) begin
						held.push_front(v);
					end else if (w.kind == ode_pkg::KIND_PUSH_BACK) begin
						held.push_back(v);
					end else begin
						// goes ahead of the first entry that is not smaller
						pos = 0;
						while (pos < held.size() && v > held[pos])
							pos++;
						held.insert(pos, v);
					end
				end
				ode_pkg::KIND_POP_FRONT, ode_pkg::KIND_POP_BACK: begin
					if (held.size() == 0) begin
						exp_word.status = ode_pkg::STAT_EMPTY;
						n_empty++;
					end else if (w.kind == ode_pkg::KIND_POP_FRONT) begin
						exp_word.popped = held.pop_front();
					end else begin
						exp_word.popped = held.pop_back();
					end
				end
				ode_pkg::KIND_REMOVE: begin
					pos = 0;
					while (pos < held.size() && held[pos] != v)
						pos++;
					if (pos >= held.size()) begin
						exp_word.status = ode_pkg::STAT_NOTFOUND;
						n_missing++;
					end else begin
						held.delete(pos);
						n_removed++;
					end
				end
				default: ;  // unused kinds do nothing
			endcase
			exp_word.count = ode_pkg::COUNT_W'(held.size());
			if (held.size() > peak)
				peak = held.size();
			expected_words.push_back(exp_word);
		endfunction

		// Compare one result word against the oldest expectation.
		function void check_result(ode_pkg::out_word_t r);
			ode_pkg::out_word_t e;
			if (expected_words.size() == 0) begin
				$display("%0t: result with nothing expected: popped %0d status %0d count %0d",
					$time, r.popped, r.status, r.count);
				mismatches++;
				return;
			end
			e = expected_words.pop_front();
			n_checked++;
			if (r.popped !== e.popped) begin
				$display("%0t: popped mismatch: expected %0d, actual %0d",
					$time, e.popped, r.popped);
				mismatches++;
			end
			if (r.status !== e.status) begin
				$display("%0t: status mismatch: expected %0d, actual %0d",
					$time, e.status, r.status);
				mismatches++;
			end
			if (r.count !== e.count) begin
				$display("%0t: count mismatch: expected %0d, actual %0d",
					$time, e.count, r.count);
				mismatches++;
			end
		endfunction
	endclass

	logic               clk    = 1'b0;
	logic               arst_n = 1'b0;
	logic               start  = 1'b0;
	logic               busy;
	ode_pkg::in_word_t  cmd    = '0;
	logic               done;
	ode_pkg::out_word_t result;

	deque_ledger ledger = new();
	int          quiet_cycles = 0;

	ordered_deque_engine_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always #2 clk = ~clk;

	// Result monitor and watchdog. Sampled at the rising edge, so every value read
	// here is the one settled during the cycle that the edge closes.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				ledger.check_result(result);
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
				$display("ordered_deque_engine_unit test failed");
				$finish;
			end
		end
	end

	// Present one word after an idle gap and hold it until the block takes it.
	// start stays high across back-to-back words; it is never dropped and
	// raised at the same edge.
	task automatic send_word(input ode_pkg::in_word_t w, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= w;
		do
			@(posedge clk);
		while (busy);
		ledger.note_command(w);
	endtask

	task automatic issue(input logic [ode_pkg::KIND_W-1:0] kind,
		input logic [ode_pkg::VALUE_W-1:0] value);
		ode_pkg::in_word_t w;
		w.kind  = kind;
		w.value = value;
		send_word(w, $urandom_range(0, 16));
	endtask

	// Many small values so that equal entries and remove hits are common; some
	// extremes, and full-range values so every data bit toggles.
	function automatic logic [ode_pkg::VALUE_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return ode_pkg::VALUE_W'($signed($urandom_range(0, 8)) - 4);
		if (r == 4) begin
			case ($urandom_range(0, 3))
				0: return 32'h7FFF_FFFF;
				1: return 32'h8000_0000;
				2: return 32'h0000_0000;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		return $urandom();
	endfunction

	function automatic ode_pkg::in_word_t make_word(mix_t mix);
		ode_pkg::in_word_t w;
		int                r;
		int                grow_pct;
		grow_pct = (mix == MIX_FILL) ? 75 : (mix == MIX_DRAIN) ? 25 : 50;
		r        = $urandom_range(0, 99);
		w.value  = pick_value();
		if ($urandom_range(0, 49) == 0)
			w.kind = ode_pkg::KIND_W'($urandom_range(6, 7));  // unused codes
		else if (r < grow_pct)
			w.kind = ode_pkg::KIND_W'($urandom_range(ode_pkg::KIND_PUSH_FRONT,
				ode_pkg::KIND_INSERT));
		else
			w.kind = ode_pkg::KIND_W'($urandom_range(ode_pkg::KIND_POP_FRONT,
				ode_pkg::KIND_REMOVE));
		// removes mostly aim at something that is actually held
		if (w.kind == ode_pkg::KIND_REMOVE && ledger.held.size() != 0
			&& $urandom_range(0, 9) < 6)
			w.value = ledger.held[$urandom_range(0, ledger.held.size() - 1)];
		return w;
	endfunction

	initial begin
		int   sent;
		int   run_len;
		bit   gaps_on;
		mix_t mix;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners: empty pops and remove, extremes at both ends, ordered
		// insert with equal values, remove of first match only, unused kinds
		issue(ode_pkg::KIND_POP_FRONT,  32'h0000_0000);
		issue(ode_pkg::KIND_POP_BACK,   32'hFFFF_FFFF);
		issue(ode_pkg::KIND_REMOVE,     32'h0000_0000);
		issue(ode_pkg::KIND_PUSH_FRONT, 32'h7FFF_FFFF);
		issue(ode_pkg::KIND_PUSH_BACK,  32'h8000_0000);
		issue(ode_pkg::KIND_INSERT,     32'h0000_0000);
		issue(ode_pkg::KIND_INSERT,     32'h0000_0000);
		issue(ode_pkg::KIND_INSERT,     32'hFFFF_FFFF);
		issue(ode_pkg::KIND_INSERT,     32'h8000_0000);
		issue(ode_pkg::KIND_INSERT,     32'h7FFF_FFFF);
		issue(ode_pkg::KIND_REMOVE,     32'h0000_0000);
		issue(ode_pkg::KIND_REMOVE,     32'h0000_0005);
		issue(3'd6,                     32'hFFFF_FFFF);
		issue(3'd7,                     32'h5555_AAAA);
		issue(ode_pkg::KIND_POP_FRONT,  32'h1234_5678);
		issue(ode_pkg::KIND_POP_BACK,   32'h0000_0000);
		issue(ode_pkg::KIND_POP_BACK,   32'h0000_0000);
		issue(ode_pkg::KIND_POP_FRONT,  32'h0000_0000);
		issue(ode_pkg::KIND_REMOVE,     32'h0000_0000);
		issue(ode_pkg::KIND_POP_FRONT,  32'h0000_0000);
		issue(ode_pkg::KIND_POP_BACK,   32'h0000_0000);

		// random runs, each leaning toward filling, draining or neither, with or
		// without idle gaps between words
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			mix     = mix_t'($urandom_range(0, 2));
			run_len = $urandom_range(10, 60);
			gaps_on = ($urandom_range(0, 2) != 0);
			repeat (run_len) begin
				send_word(make_word(mix), gaps_on ? $urandom_range(0, 16) : 0);
				sent++;
			end
		end
		start <= 1'b0;

		while (ledger.expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d command words, checked %0d results; peak fill %0d of %0d.",
			ledger.n_words, ledger.n_checked, ledger.peak, CAPACITY);
		$display("Full rejects %0d, empty pops %0d, remove hits %0d, remove misses %0d.",
			ledger.n_full, ledger.n_empty, ledger.n_removed, ledger.n_missing);
		if (ledger.mismatches == 0 && ledger.expected_words.size() == 0) begin
			$display("ordered_deque_engine_unit test passed");
		end else begin
			$display("ordered_deque_engine_unit test failed");
		end
		$finish;
	end

endmodule

// ===== ordered_deque_engine_unit.f =====
hdl/ode_pkg.sv
hdl/ode_cell.sv
hdl/ordered_deque_engine_unit.sv
dv/ordered_deque_engine_unit_tb.sv
